// ----- rtl/fbb_pkg.sv -----
// Shared constants and types for the framebuffer fill and sprite blitter.
`timescale 1ns / 1ps
package fbb_pkg;
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 128;
	localparam int TEXEL_WORDS   = 4096;

	localparam int XW   = $clog2(SCREEN_WIDTH);
	localparam int YW   = $clog2(SCREEN_HEIGHT);
	localparam int FAW  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
	localparam int TW   = $clog2(TEXEL_WORDS);
	localparam int CW   = 15;
	localparam int PW   = 13;
	localparam int AW   = 5;

	localparam logic [2:0] FN_TEXEL = 3'd0;
	localparam logic [2:0] FN_CLEAR = 3'd1;
	localparam logic [2:0] FN_FILL  = 3'd2;
	localparam logic [2:0] FN_HLINE = 3'd3;
	localparam logic [2:0] FN_BLIT  = 3'd4;
	localparam logic [2:0] FN_READ  = 3'd5;

	localparam logic [2:0] REG_RED   = 3'd0;
	localparam logic [2:0] REG_GREEN = 3'd1;
	localparam logic [2:0] REG_BLUE  = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_PITCH = 3'd4;

	typedef struct packed {
		logic [7:0]    red;
		logic [7:0]    green;
		logic [7:0]    blue;
		logic [7:0]    alpha;
		logic [PW-1:0] pitch;
	} fbb_cfg_t;

	typedef struct packed {
		logic load;
		logic init;
		logic setup;
		logic issue;
	} fbb_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} fbb_sts_t;
endpackage

// ----- rtl/fbb_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module fbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/fbb_ctrl.sv -----
// Command sequencer for the blitter.
`timescale 1ns / 1ps
module fbb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fbb_pkg::fbb_sts_t sts,
	output fbb_pkg::fbb_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import fbb_pkg::*;

	typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_SETUP, ST_RUN, ST_WAIT1, ST_WAIT2} state_t;

	state_t state_q;
	logic   init_q;

	assign busy      = (state_q != ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.init  = (state_q == ST_INIT);
	assign cmd.setup = (state_q == ST_SETUP);
	assign cmd.issue = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= 1'b1;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_INIT: state_q <= ST_SETUP;
				ST_IDLE: if (start) state_q <= ST_SETUP;
				ST_SETUP: state_q <= sts.empty ? ST_WAIT1 : ST_RUN;
				ST_RUN: if (sts.last) state_q <= ST_WAIT1;
				ST_WAIT1: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					state_q <= ST_IDLE;
					done    <= !init_q;
					init_q  <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/fbb_dp.sv -----
// Clipping, pixel walker, blend pipeline and stores of the blitter.
`timescale 1ns / 1ps
module fbb_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fbb_pkg::fbb_cmd_t cmd,
	output fbb_pkg::fbb_sts_t sts,
	input  fbb_pkg::fbb_cfg_t cfg,
	input  logic [2:0]        func,
	input  logic signed [11:0] dest_x,
	input  logic signed [11:0] dest_y,
	input  logic signed [11:0] span_width,
	input  logic signed [11:0] span_height,
	input  logic [11:0]       src_col,
	input  logic [11:0]       src_row,
	input  logic              mirror_x,
	input  logic              mirror_y,
	input  logic [11:0]       texel_addr,
	input  logic [31:0]       data_word,
	output logic [23:0]       pixel_value
);
	import fbb_pkg::*;

	localparam logic signed [CW-1:0] SW_S = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SH_S = CW'(SCREEN_HEIGHT);

	logic [2:0]        func_q;
	logic signed [11:0] dx_q, dy_q, sw_q, sh_q;
	logic [11:0]       sc_q, sr_q;
	logic              mx_q, my_q;
	logic [23:0]       data_q;

	logic signed [CW-1:0] x, y, w, h, sx, sy, stx, sty;
	logic              known;

	logic [XW-1:0] x0_q, px_q, cc_q, lastc_q;
	logic [YW-1:0] py_q, rc_q, lastr_q;
	logic [CW-1:0] stx_q, tx_q, ty_q;

	logic           valid_s1, valid_s2;
	logic [FAW-1:0] fa_s1, fa_s2;
	logic [TW-1:0]  ta_s1;
	logic [23:0]    frd;
	logic [31:0]    trd;

	logic [7:0]  sr8, sg8, sb8, sa8;
	logic [23:0] src, mixed, wdata;
	logic        fwe;

	always_comb begin
		x = CW'(dx_q);
		y = CW'(dy_q);
		w = CW'(sw_q);
		h = CW'(sh_q);
		sx = CW'(sc_q);
		sy = CW'(sr_q);
		if (func_q == FN_CLEAR) begin
			x = '0;
			y = '0;
			w = SW_S;
			h = SH_S;
		end
		if (func_q == FN_HLINE || func_q == FN_READ) h = CW'(1);
		if (func_q == FN_READ) w = CW'(1);
		if (x < 0) begin
			sx = sx - x;
			w  = w + x;
			x  = '0;
		end
		if (y < 0) begin
			sy = sy - y;
			h  = h + y;
			y  = '0;
		end
		if (x + w > SW_S) w = SW_S - x;
		if (y + h > SH_S) h = SH_S - y;
		stx = mx_q ? sx + w - CW'(1) : sx;
		sty = my_q ? sy + h - CW'(1) : sy;
		known = (func_q == FN_CLEAR) || (func_q == FN_FILL) || (func_q == FN_HLINE) ||
			(func_q == FN_BLIT) || (func_q == FN_READ);
		sts.empty = (w <= 0) || (h <= 0) || !known;
		sts.last  = (cc_q == lastc_q) && (rc_q == lastr_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			dx_q   <= dest_x;
			dy_q   <= dest_y;
			sw_q   <= span_width;
			sh_q   <= span_height;
			sc_q   <= src_col;
			sr_q   <= src_row;
			mx_q   <= mirror_x;
			my_q   <= mirror_y;
			data_q <= data_word[23:0];
		end
		if (cmd.init) begin
			func_q <= FN_CLEAR;
			mx_q   <= 1'b0;
			my_q   <= 1'b0;
			data_q <= '0;
		end
		if (cmd.setup) begin
			x0_q    <= XW'(x);
			px_q    <= XW'(x);
			py_q    <= YW'(y);
			lastc_q <= XW'(w - CW'(1));
			lastr_q <= YW'(h - CW'(1));
			cc_q    <= '0;
			rc_q    <= '0;
			stx_q   <= stx;
			tx_q    <= stx;
			ty_q    <= sty;
		end else if (cmd.issue) begin
			if (cc_q == lastc_q) begin
				cc_q <= '0;
				px_q <= x0_q;
				tx_q <= stx_q;
				rc_q <= rc_q + YW'(1);
				py_q <= py_q + YW'(1);
				ty_q <= my_q ? ty_q - CW'(1) : ty_q + CW'(1);
			end else begin
				cc_q <= cc_q + XW'(1);
				px_q <= px_q + XW'(1);
				tx_q <= mx_q ? tx_q - CW'(1) : tx_q + CW'(1);
			end
		end
		fa_s1 <= FAW'(py_q) * FAW'(SCREEN_WIDTH) + FAW'(px_q);
		ta_s1 <= TW'(({PW'(0), ty_q} * {CW'(0), cfg.pitch}) + (CW + PW)'(tx_q));
		fa_s2 <= fa_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			pixel_value <= '0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (cmd.load) begin
				pixel_value <= '0;
			end else if (valid_s2 && func_q == FN_READ) begin
				pixel_value <= frd;
			end
		end
	end

	always_comb begin
		case (func_q)
			FN_BLIT: begin
				sr8 = trd[31:24];
				sg8 = trd[23:16];
				sb8 = trd[15:8];
				sa8 = trd[7:0];
			end
			FN_CLEAR: begin
				sr8 = data_q[23:16];
				sg8 = data_q[15:8];
				sb8 = data_q[7:0];
				sa8 = 8'hFF;
			end
			default: begin
				sr8 = cfg.red;
				sg8 = cfg.green;
				sb8 = cfg.blue;
				sa8 = cfg.alpha;
			end
		endcase
		src   = {sr8, sg8, sb8};
		mixed = {8'((16'(sr8) * 16'(sa8) + 16'(frd[23:16]) * 16'(8'hFF - sa8)) >> 8),
			8'((16'(sg8) * 16'(sa8) + 16'(frd[15:8]) * 16'(8'hFF - sa8)) >> 8),
			8'((16'(sb8) * 16'(sa8) + 16'(frd[7:0]) * 16'(8'hFF - sa8)) >> 8)};
		wdata = (sa8 == 8'hFF) ? src : mixed;
		fwe   = valid_s2 && (func_q != FN_READ) && (sa8 != 8'h00);
	end

	fbb_ram #(.WIDTH(24), .DEPTH(SCREEN_WIDTH * SCREEN_HEIGHT)) u_frame (
		.clk  (clk),
		.we   (fwe),
		.waddr(fa_s2),
		.wdata(wdata),
		.raddr(fa_s1),
		.rdata(frd)
	);

	fbb_ram #(.WIDTH(32), .DEPTH(TEXEL_WORDS)) u_texel (
		.clk  (clk),
		.we   (cmd.load && func == FN_TEXEL),
		.waddr(TW'(texel_addr)),
		.wdata(data_word),
		.raddr(ta_s1),
		.rdata(trd)
	);
endmodule

// ----- rtl/framebuffer_fill_and_sprite_blitter.sv -----
// Top level of the framebuffer fill and sprite blitter.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and must be taken then. A request passes
// through setup, a walk that issues each clipped pixel in turn to the frame
// store read-modify-write port, and the wait states. Texel writes and empty
// shapes skip the walk. After reset a clearing pass zeroes the frame store,
// with busy high.
module framebuffer_fill_and_sprite_blitter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [fbb_pkg::AW-1:0]   paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic [2:0]               func,
	input  logic signed [11:0]       dest_x,
	input  logic signed [11:0]       dest_y,
	input  logic signed [11:0]       span_width,
	input  logic signed [11:0]       span_height,
	input  logic [11:0]              src_col,
	input  logic [11:0]              src_row,
	input  logic                     mirror_x,
	input  logic                     mirror_y,
	input  logic [11:0]              texel_addr,
	input  logic [31:0]              data_word,
	output logic [23:0]              pixel_value,
	output logic                     command_done
);
	import fbb_pkg::*;

	fbb_cfg_t cfg_q;
	fbb_cmd_t cmd;
	fbb_sts_t sts;

	assign pready       = 1'b1;
	assign command_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red   <= 8'hFF;
			cfg_q.green <= 8'hFF;
			cfg_q.blue  <= 8'hFF;
			cfg_q.alpha <= 8'hFF;
			cfg_q.pitch <= PW'(64);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_RED:   cfg_q.red   <= pwdata[7:0];
				REG_GREEN: cfg_q.green <= pwdata[7:0];
				REG_BLUE:  cfg_q.blue  <= pwdata[7:0];
				REG_ALPHA: cfg_q.alpha <= pwdata[7:0];
				REG_PITCH: cfg_q.pitch <= pwdata[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_RED:   prdata = 32'(cfg_q.red);
			REG_GREEN: prdata = 32'(cfg_q.green);
			REG_BLUE:  prdata = 32'(cfg_q.blue);
			REG_ALPHA: prdata = 32'(cfg_q.alpha);
			REG_PITCH: prdata = 32'(cfg_q.pitch);
			default:   prdata = '0;
		endcase
	end

	fbb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	fbb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg        (cfg_q),
		.func       (func),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.span_width (span_width),
		.span_height(span_height),
		.src_col    (src_col),
		.src_row    (src_row),
		.mirror_x   (mirror_x),
		.mirror_y   (mirror_y),
		.texel_addr (texel_addr),
		.data_word  (data_word),
		.pixel_value(pixel_value)
	);
endmodule

// ----- rtl/fbb_chk.sv -----
// Port-level checks of the blitter request and result timing.
`timescale 1ns / 1ps
module fbb_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request taken without busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done) else $error("result right after request");
endmodule

bind framebuffer_fill_and_sprite_blitter fbb_chk u_chk (.*);

// ----- bench/framebuffer_fill_and_sprite_blitter_tb.sv -----
// Self-checking testbench for the sprite blitter: texel preload, directed table, then random commands.
`timescale 1ns / 1ps
module framebuffer_fill_and_sprite_blitter_tb;
	import fbb_pkg::*;

	typedef struct {
		logic [2:0]         func;
		logic signed [11:0] dx;
		logic signed [11:0] dy;
		logic signed [11:0] sw;
		logic signed [11:0] sh;
		logic [11:0]        scol;
		logic [11:0]        srow;
		logic               mx;
		logic               my;
		logic [11:0]        taddr;
		logic [31:0]        data;
		bit                 known;
		logic [23:0]        kpix;
	} draw_req_t;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy, done;
	logic [2:0] func = '0;
	logic signed [11:0] dest_x = '0, dest_y = '0, span_width = '0, span_height = '0;
	logic [11:0] src_col = '0, src_row = '0, texel_addr = '0;
	logic mirror_x = 0, mirror_y = 0;
	logic [31:0] data_word = '0;
	logic [23:0] pixel_value;
	logic command_done;

	logic [23:0] frame_mem [SCREEN_WIDTH*SCREEN_HEIGHT];
	logic [31:0] texel_mem [TEXEL_WORDS];
	bit texel_set [TEXEL_WORDS];
	logic [7:0] fill_r, fill_g, fill_b, fill_a;
	logic [PW-1:0] pitch;
	logic [23:0] pixel_q [$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int send_idle = 0;
	draw_req_t table_rows [$];

	framebuffer_fill_and_sprite_blitter uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#150ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		int unsigned v;
		v = (s * a + d * (255 - a)) >> 8;
		return v[7:0];
	endfunction

	function automatic void plot(input int x, input int y, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
		logic [23:0] d;
		if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT || a == 0)
			return;
		d = frame_mem[y*SCREEN_WIDTH + x];
		if (a == 8'hFF)
			frame_mem[y*SCREEN_WIDTH + x] = {r, g, b};
		else
			frame_mem[y*SCREEN_WIDTH + x] = {mix(r, d[23:16], a), mix(g, d[15:8], a),
				mix(b, d[7:0], a)};
	endfunction

	function automatic logic [23:0] draw_step(input draw_req_t q);
		int x, y, w, h, sx, sy, tx, ty, bx, by;
		longint ad;
		logic [31:0] t;
		x = int'(q.dx); y = int'(q.dy); w = int'(q.sw); h = int'(q.sh);
		sx = int'(q.scol); sy = int'(q.srow);
		case (q.func)
			FN_TEXEL: begin
				texel_mem[q.taddr] = q.data;
				texel_set[q.taddr] = 1'b1;
			end
			FN_CLEAR: foreach (frame_mem[i]) frame_mem[i] = q.data[23:0];
			FN_FILL: begin
				if (w <= 0 || h <= 0) return '0;
				if (x < 0) begin w += x; x = 0; end
				if (y < 0) begin h += y; y = 0; end
				if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
				if (y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - y;
				for (int j = 0; j < h; j++)
					for (int i = 0; i < w; i++)
						plot(x + i, y + j, fill_r, fill_g, fill_b, fill_a);
			end
			FN_HLINE: begin
				if (y < 0 || y >= SCREEN_HEIGHT) return '0;
				if (x < 0) begin w += x; x = 0; end
				if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
				for (int i = 0; i < w; i++)
					plot(x + i, y, fill_r, fill_g, fill_b, fill_a);
			end
			FN_BLIT: begin
				if (x < 0) begin sx -= x; w += x; x = 0; end
				if (y < 0) begin sy -= y; h += y; y = 0; end
				if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
				if (y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - y;
				if (w <= 0 || h <= 0) return '0;
				bx = q.mx ? sx + w - 1 : sx;
				by = q.my ? sy + h - 1 : sy;
				for (int j = 0; j < h; j++) begin
					ty = q.my ? by - j : by + j;
					for (int i = 0; i < w; i++) begin
						tx = q.mx ? bx - i : bx + i;
						ad = longint'(ty) * pitch + tx;
						t = texel_mem[ad % TEXEL_WORDS];
						plot(x + i, y + j, t[31:24], t[23:16], t[15:8], t[7:0]);
					end
				end
			end
			FN_READ:
				if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT)
					return frame_mem[y*SCREEN_WIDTH + x];
			default: ;
		endcase
		return '0;
	endfunction

	function automatic bit blit_safe(input draw_req_t q);
		int x, y, w, h, sx, sy, tx, ty, bx, by;
		longint ad;
		x = int'(q.dx); y = int'(q.dy); w = int'(q.sw); h = int'(q.sh);
		sx = int'(q.scol); sy = int'(q.srow);
		if (x < 0) begin sx -= x; w += x; x = 0; end
		if (y < 0) begin sy -= y; h += y; y = 0; end
		if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
		if (y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - y;
		if (w <= 0 || h <= 0) return 1'b1;
		bx = q.mx ? sx + w - 1 : sx;
		by = q.my ? sy + h - 1 : sy;
		for (int j = 0; j < h; j++) begin
			ty = q.my ? by - j : by + j;
			for (int i = 0; i < w; i++) begin
				tx = q.mx ? bx - i : bx + i;
				ad = longint'(ty) * pitch + tx;
				if (!texel_set[ad % TEXEL_WORDS]) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic draw_req_t mk(input logic [2:0] f, input int x, input int y,
			input int w, input int h, input int sc, input int sr, input bit mx,
			input bit my, input int ta, input logic [31:0] dw, input bit known = 0,
			input logic [23:0] kp = '0);
		draw_req_t q;
		q.func = f; q.dx = 12'(x); q.dy = 12'(y); q.sw = 12'(w); q.sh = 12'(h);
		q.scol = 12'(sc); q.srow = 12'(sr); q.mx = mx; q.my = my; q.taddr = 12'(ta);
		q.data = dw; q.known = known; q.kpix = kp;
		return q;
	endfunction

	task automatic send_req(input draw_req_t q);
		logic [23:0] p;
		func <= q.func; dest_x <= q.dx; dest_y <= q.dy;
		span_width <= q.sw; span_height <= q.sh;
		src_col <= q.scol; src_row <= q.srow;
		mirror_x <= q.mx; mirror_y <= q.my;
		texel_addr <= q.taddr; data_word <= q.data;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = draw_step(q);
		pixel_q.push_back(q.known ? q.kpix : p);
		n_sent++;
		if ($urandom_range(0, 99) < send_idle) begin
			start <= 0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= AW'(4 * idx); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_RED:   fill_r = v[7:0];
			REG_GREEN: fill_g = v[7:0];
			REG_BLUE:  fill_b = v[7:0];
			REG_ALPHA: fill_a = v[7:0];
			default:   pitch = v[PW-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_colors(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input logic [PW-1:0] p);
		write_reg(REG_RED, 32'(r));
		write_reg(REG_GREEN, 32'(g));
		write_reg(REG_BLUE, 32'(b));
		write_reg(REG_ALPHA, 32'(a));
		write_reg(REG_PITCH, 32'(p));
	endtask

	function automatic draw_req_t rand_req();
		draw_req_t q;
		int r;
		bit wide;
		r = $urandom_range(0, 99);
		wide = $urandom_range(0, 19) == 0;
		q = mk(FN_READ, int'($urandom_range(0, 143)) - 8, int'($urandom_range(0, 143)) - 8,
			int'($urandom_range(0, 28)) - 4, int'($urandom_range(0, 28)) - 4,
			int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			int'($urandom_range(0, 127)), $urandom());
		if (wide) begin
			q.dx = 12'($urandom()); q.dy = 12'($urandom());
			q.sw = 12'($urandom()); q.sh = 12'($urandom());
		end
		if (r < 20) q.func = FN_TEXEL;
		else if (r < 23) q.func = FN_CLEAR;
		else if (r < 43) q.func = FN_FILL;
		else if (r < 58) q.func = FN_HLINE;
		else if (r < 78) q.func = FN_BLIT;
		else if (r < 97) q.func = FN_READ;
		else q.func = r[0] ? FN_SPARE7 : FN_SPARE6;
		if (q.func == FN_BLIT) begin
			for (int n = 0; n < 64 && !blit_safe(q); n++) begin
				q.dx = 12'(int'($urandom_range(0, 139)) - 6);
				q.dy = 12'(int'($urandom_range(0, 139)) - 6);
				q.sw = 12'(int'($urandom_range(0, 10)) - 2);
				q.sh = 12'(int'($urandom_range(0, 4)) - 1);
				q.scol = 12'($urandom_range(0, 11));
				q.srow = 12'($urandom_range(0, 1));
			end
			if (!blit_safe(q)) q.func = FN_READ;
		end
		return q;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected result: pixel_value %h", pixel_value);
				errors++;
			end else begin
				logic [23:0] e;
				e = pixel_q.pop_front();
				n_checked++;
				if (pixel_value !== e) begin
					$error("pixel_value expected %h actual %h", e, pixel_value);
					errors++;
				end
				if (command_done !== 1'b1) begin
					$error("command_done expected 1 actual %b", command_done);
					errors++;
				end
			end
		end
	end

	initial begin
		foreach (frame_mem[i]) frame_mem[i] = '0;
		fill_r = 8'hFF; fill_g = 8'hFF; fill_b = 8'hFF; fill_a = 8'hFF;
		pitch = PW'(64);
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		table_rows.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFABCDEF, 1, 24'h0));
		table_rows.push_back(mk(FN_READ, 64, 3, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'hABCDEF));
		table_rows.push_back(mk(FN_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_READ, 2047, -2048, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_READ, 0, 128, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_SPARE6, 5, 5, 9, 9, 0, 0, 0, 0, 0, '1, 1, 24'h0));
		table_rows.push_back(mk(FN_SPARE7, 5, 5, 9, 9, 0, 0, 0, 0, 0, '1, 1, 24'h0));
		table_rows.push_back(mk(FN_FILL, -5, -5, 20, 20, 0, 0, 0, 0, 0, 0, 1, 24'h0));
		table_rows.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 24'hFFFFFF));
		table_rows.push_back(mk(FN_FILL, -2048, -2048, 2047, 2047, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_FILL, 10, 10, 0, 5, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_FILL, 10, 10, -2048, 5, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_HLINE, -2048, 127, 2047, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_HLINE, 3, -1, 50, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_HLINE, 3, 128, 50, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_HLINE, 120, 40, 30, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_BLIT, -3, -1, 10, 2, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_BLIT, 124, 126, 12, 5, 0, 0, 1, 0, 0, 0));
		table_rows.push_back(mk(FN_BLIT, 30, 30, 7, 2, 5, 0, 0, 1, 0, 0));
		table_rows.push_back(mk(FN_BLIT, 40, 50, 6, 2, 2, 0, 1, 1, 0, 0));
		table_rows.push_back(mk(FN_TEXEL, 0, 0, 0, 0, 0, 0, 0, 0, 4095, 32'h12345680));
		table_rows.push_back(mk(FN_BLIT, 60, 60, 2, 1, 4095, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(FN_READ, 125, 40, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int rw = 0; rw < 2; rw++)
			for (int c = 0; c < 12; c++)
				send_req(mk(FN_TEXEL, 0, 0, 0, 0, 0, 0, 0, 0, rw * 64 + c, $urandom()));
		drain();
		foreach (table_rows[i]) send_req(table_rows[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_colors(8'h00, 8'h80, 8'hFF, 8'h80, PW'(1));
				1: set_colors(8'hFF, 8'h00, 8'h5A, 8'h00, PW'(4096));
				2: set_colors(8'h37, 8'hC4, 8'h00, 8'hFF, PW'(0));
				3: set_colors(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h01,
					PW'(8191));
				default: set_colors(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'hFE,
					PW'(37));
			endcase
			send_idle = ph < 2 ? 34 : (ph < 4 ? 46 : 0);
			for (int k = 0; k < 12; k++) begin
				if (ph == 1 && k == 6) drain();
				send_req(rand_req());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d requests, checked %0d results: texel preload, directed table,",
			n_sent, n_checked);
		$display("five color/alpha/pitch settings with random fill, line, blit and reads.");
		if (errors == 0 && pixel_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
